// File: hw/rtl/cbte_pkg.sv
package cbte_pkg;

  // Payload width of a stored node value
  localparam int unsigned ValueW = 32;

  // Request kinds
  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_SEARCH = 3'd1,
    KIND_PRE    = 3'd2,
    KIND_IN     = 3'd3,
    KIND_POST   = 3'd4,
    KIND_LEVEL  = 3'd5
  } kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

endpackage

// File: hw/rtl/cbte_in_if.sv
interface cbte_in_if;
  logic                               valid;
  logic                               ready;
  logic [2:0]                         kind;
  logic signed [cbte_pkg::ValueW-1:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

// File: hw/rtl/cbte_out_if.sv
interface cbte_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [cbte_pkg::ValueW-1:0] item_value;
  logic                               found;
  logic [1:0]                         status;
  logic                               last;

  modport source (output valid, item_value, found, status, last, input ready);
  modport sink   (input valid, item_value, found, status, last, output ready);
endinterface

// File: hw/rtl/complete_binary_tree_engine_unit.sv
// Complete binary tree engine: values kept in level order in a node RAM.
// Request channel in_i (kind, value): insert, search, or a traversal
// (preorder, inorder, postorder, level order). Result channel out_o carries
// item_value, found, status and last; last marks the final result of a request.
// Both channels are valid/ready; a transaction happens when both are high.
// Steps, with n the number of stored nodes:
//   insert      : RAM write at acceptance; then read stage, output register.
//   search      : n RAM reads, a compare, the read stage, the output register.
//   level order : one node per cycle while the read stage can take it.
//   pre/in/post : a stackless walker moves one tree edge a cycle and emits at
//                 most one node per move; an emitting move waits for a free
//                 read stage.
// One read port on the node RAM paces search and walks. Kinds 6 and 7 are
// taken and dropped without a result.
// Reset empties the tree (count to zero); the RAM itself is not cleared.
// A stalled receiver holds the output register; the walker then waits at an
// emitting move while the read stage in front of it is full, so nothing is lost.
module complete_binary_tree_engine_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cbte_in_if.sink    in_i,
  cbte_out_if.source out_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned JW = $clog2(2 * CAPACITY + 2);
  localparam int unsigned VW = cbte_pkg::ValueW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_WALK
  } state_e;

  state_e             st_q, st_d;
  cbte_pkg::kind_e    kind_q, kind_d;
  logic signed [VW-1:0] value_q, value_d;
  logic [CW-1:0]      count_q, count_d;
  logic [JW-1:0]      j_q, j_d;
  logic               up_q, up_d;
  logic [CW-1:0]      ecount_q, ecount_d;
  logic [CW-1:0]      scan_q, scan_d;
  logic               cmp_q, cmp_d;
  logic               hit_q, hit_d;

  logic               s1_valid_q, s1_valid_d;
  logic               s1_mem_q, s1_mem_d;
  logic               s1_found_q, s1_found_d;
  cbte_pkg::status_e  s1_status_q, s1_status_d;
  logic               s1_last_q, s1_last_d;

  logic               out_valid_q, out_valid_d;
  logic signed [VW-1:0] out_item_q, out_item_d;
  logic               out_found_q, out_found_d;
  cbte_pkg::status_e  out_status_q, out_status_d;
  logic               out_last_q, out_last_d;

  // Node RAM, one write and one registered read per cycle
  logic signed [VW-1:0] mem [CAPACITY];
  logic signed [VW-1:0] rd_data_q;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;

  logic               accept, s1_move, s1_free, match;
  logic [CW-1:0]      count_m1;

  // Walker step
  logic [JW:0]        n_ext, j2, j_inc_ext;
  logic [JW-1:0]      parent, emit_idx, w_next_j, emit_m1;
  logic               w_emit, w_next_up, w_done, w_last;

  assign in_i.ready = (st_q == ST_IDLE) && !s1_valid_q;
  assign accept     = in_i.valid && in_i.ready;
  assign s1_move    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign s1_free    = !s1_valid_q || s1_move;
  assign match      = cmp_q && (rd_data_q == value_q);
  assign count_m1   = count_q - CW'(1);

  assign out_o.valid      = out_valid_q;
  assign out_o.item_value = out_item_q;
  assign out_o.found      = out_found_q;
  assign out_o.status     = out_status_q;
  assign out_o.last       = out_last_q;

  // Next move of the stackless walker (1-based heap index j)
  always_comb begin
    n_ext     = (JW+1)'(count_q);
    j2        = {j_q, 1'b0};
    j_inc_ext = (JW+1)'(j_q) + (JW+1)'(1);
    parent    = j_q >> 1;
    w_emit    = 1'b0;
    w_done    = 1'b0;
    emit_idx  = j_q;
    w_next_j  = j_q;
    w_next_up = up_q;
    if (kind_q == cbte_pkg::KIND_LEVEL) begin
      w_emit    = 1'b1;
      w_next_j  = j_inc_ext[JW-1:0];
    end else if (!up_q) begin
      if (j2 <= n_ext) begin
        // descend to the left child
        w_emit    = (kind_q == cbte_pkg::KIND_PRE);
        w_next_j  = j2[JW-1:0];
        w_next_up = 1'b0;
      end else begin
        // leaf: visited in every order
        w_emit    = 1'b1;
        w_next_up = 1'b1;
      end
    end else if (j_q == JW'(1)) begin
      w_done = 1'b1;
    end else begin
      emit_idx = parent;
      if (!j_q[0]) begin
        if (j_inc_ext <= n_ext) begin
          // back from the left, go down the right subtree
          w_emit    = (kind_q == cbte_pkg::KIND_IN);
          w_next_j  = j_inc_ext[JW-1:0];
          w_next_up = 1'b0;
        end else begin
          w_emit    = (kind_q == cbte_pkg::KIND_IN) || (kind_q == cbte_pkg::KIND_POST);
          w_next_j  = parent;
          w_next_up = 1'b1;
        end
      end else begin
        w_emit    = (kind_q == cbte_pkg::KIND_POST);
        w_next_j  = parent;
        w_next_up = 1'b1;
      end
    end
    emit_m1 = emit_idx - JW'(1);
    w_last  = (ecount_q == count_m1);
  end

  // Sequencer and pipeline control
  always_comb begin
    st_d        = st_q;
    kind_d      = kind_q;
    value_d     = value_q;
    count_d     = count_q;
    j_d         = j_q;
    up_d        = up_q;
    ecount_d    = ecount_q;
    scan_d      = scan_q;
    cmp_d       = 1'b0;
    hit_d       = hit_q | match;
    s1_valid_d  = s1_valid_q && !s1_move;
    s1_mem_d    = s1_mem_q;
    s1_found_d  = s1_found_q;
    s1_status_d = s1_status_q;
    s1_last_d   = s1_last_q;
    rd_en       = 1'b0;
    rd_addr     = scan_q[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = count_q[AW-1:0];

    // output register takes the read stage
    out_valid_d  = out_valid_q && !out_o.ready;
    out_item_d   = out_item_q;
    out_found_d  = out_found_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    if (s1_move) begin
      out_valid_d  = 1'b1;
      out_item_d   = s1_mem_q ? rd_data_q : '0;
      out_found_d  = s1_found_q;
      out_status_d = s1_status_q;
      out_last_d   = s1_last_q;
    end

    unique case (st_q)
      ST_IDLE: begin
        if (accept) begin
          kind_d   = cbte_pkg::kind_e'(in_i.kind);
          value_d  = in_i.value;
          hit_d    = 1'b0;
          j_d      = JW'(1);
          up_d     = 1'b0;
          ecount_d = '0;
          scan_d   = '0;
          unique case (cbte_pkg::kind_e'(in_i.kind))
            cbte_pkg::KIND_INSERT: begin
              s1_valid_d = 1'b1;
              s1_mem_d   = 1'b0;
              s1_found_d = 1'b0;
              s1_last_d  = 1'b1;
              if (count_q >= CW'(CAPACITY)) begin
                s1_status_d = cbte_pkg::STATUS_FULL;
              end else begin
                s1_status_d = cbte_pkg::STATUS_OK;
                wr_en       = 1'b1;
                count_d     = count_q + CW'(1);
              end
            end
            cbte_pkg::KIND_SEARCH: begin
              if (count_q == '0) begin
                s1_valid_d  = 1'b1;
                s1_mem_d    = 1'b0;
                s1_found_d  = 1'b0;
                s1_status_d = cbte_pkg::STATUS_OK;
                s1_last_d   = 1'b1;
              end else begin
                st_d = ST_SCAN;
              end
            end
            cbte_pkg::KIND_PRE, cbte_pkg::KIND_IN,
            cbte_pkg::KIND_POST, cbte_pkg::KIND_LEVEL: begin
              if (count_q == '0) begin
                s1_valid_d  = 1'b1;
                s1_mem_d    = 1'b0;
                s1_found_d  = 1'b0;
                s1_status_d = cbte_pkg::STATUS_EMPTY;
                s1_last_d   = 1'b1;
              end else begin
                st_d = ST_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // one stored value read per cycle, compared the cycle after
        rd_en  = 1'b1;
        cmp_d  = 1'b1;
        scan_d = scan_q + CW'(1);
        if (scan_q == count_m1) begin
          st_d = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        s1_valid_d  = 1'b1;
        s1_mem_d    = 1'b0;
        s1_found_d  = hit_q | match;
        s1_status_d = cbte_pkg::STATUS_OK;
        s1_last_d   = 1'b1;
        st_d        = ST_IDLE;
      end
      ST_WALK: begin
        if (w_done) begin
          st_d = ST_IDLE;
        end else if (!w_emit || s1_free) begin
          j_d  = w_next_j;
          up_d = w_next_up;
          if (w_emit) begin
            rd_en       = 1'b1;
            rd_addr     = emit_m1[AW-1:0];
            s1_valid_d  = 1'b1;
            s1_mem_d    = 1'b1;
            s1_found_d  = 1'b0;
            s1_status_d = cbte_pkg::STATUS_OK;
            s1_last_d   = w_last;
            ecount_d    = ecount_q + CW'(1);
            if (w_last) begin
              st_d = ST_IDLE;
            end
          end
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      kind_q       <= cbte_pkg::KIND_INSERT;
      value_q      <= '0;
      count_q      <= '0;
      j_q          <= '0;
      up_q         <= 1'b0;
      ecount_q     <= '0;
      scan_q       <= '0;
      cmp_q        <= 1'b0;
      hit_q        <= 1'b0;
      s1_valid_q   <= 1'b0;
      s1_mem_q     <= 1'b0;
      s1_found_q   <= 1'b0;
      s1_status_q  <= cbte_pkg::STATUS_OK;
      s1_last_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      out_item_q   <= '0;
      out_found_q  <= 1'b0;
      out_status_q <= cbte_pkg::STATUS_OK;
      out_last_q   <= 1'b0;
    end else begin
      st_q         <= st_d;
      kind_q       <= kind_d;
      value_q      <= value_d;
      count_q      <= count_d;
      j_q          <= j_d;
      up_q         <= up_d;
      ecount_q     <= ecount_d;
      scan_q       <= scan_d;
      cmp_q        <= cmp_d;
      hit_q        <= hit_d;
      s1_valid_q   <= s1_valid_d;
      s1_mem_q     <= s1_mem_d;
      s1_found_q   <= s1_found_d;
      s1_status_q  <= s1_status_d;
      s1_last_q    <= s1_last_d;
      out_valid_q  <= out_valid_d;
      out_item_q   <= out_item_d;
      out_found_q  <= out_found_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
    end
  end

  // Node RAM
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= value_d;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("node count above capacity");

  a_walk_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_WALK) |-> (ecount_q < count_q))
    else $error("walker emitted more nodes than stored");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_i.kind == cbte_pkg::KIND_INSERT) && (count_q < CW'(CAPACITY)))
    |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not grow the tree");

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SCAN || st_q == ST_WALK) |-> !in_i.ready)
    else $error("request taken while busy");

endmodule
